// File: sv/tvp_pkg.sv
// ----------------------------------------------------------------------------
// tvp_pkg
// Widths, register map, beat types and helpers for the trackball projection.
// ----------------------------------------------------------------------------
package tvp_pkg;

  localparam int FRAC_BITS = 12;

  localparam int PIX_W  = 14;
  localparam int CUR_W  = 15;
  localparam int DLT_W  = 16;
  localparam int MAG_W  = 15;
  localparam int RAD_W  = 15;
  localparam int R2_W   = 2 * RAD_W;
  localparam int OUT_W  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  // scale divider: (|d| << (F+2)) + s over 2s
  localparam int SQ_W   = MAG_W + FRAC_BITS + 3;
  localparam int DEN_W  = PIX_W + 1;

  // clamped component, squares, root, z divider
  localparam int AX_W   = 31;
  localparam longint CAP = 64'd1 << 30;
  localparam int AX2_W  = 2 * AX_W;
  localparam int SUM_W  = AX2_W + 1;
  localparam int V_W    = SUM_W + 1;
  localparam int RT_W   = V_W / 2;
  localparam int RM_W   = RT_W + 1;
  localparam int SR_W   = RT_W + 1;
  localparam int ZW     = SR_W + 1;

  localparam int OUT_MAX = 32767;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [RAD_W-1:0] RADIUS_RST = 15'd4506;

  typedef enum logic [2:0] {
    REG_XMIN   = 3'd0,
    REG_XMAX   = 3'd1,
    REG_YMIN   = 3'd2,
    REG_YMAX   = 3'd3,
    REG_RADIUS = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] xmin;
    logic [PIX_W-1:0] xmax;
    logic [PIX_W-1:0] ymin;
    logic [PIX_W-1:0] ymax;
    logic [RAD_W-1:0] radius;
  } cfg_t;

  typedef struct packed {
    logic                    degen;
    logic signed [DLT_W-1:0] dx;
    logic signed [DLT_W-1:0] dy;
    logic [PIX_W-1:0]        s;
  } fq_t;

  typedef struct packed {
    logic                    degen;
    logic                    nx;
    logic                    ny;
    logic                    sphere;
    logic signed [OUT_W-1:0] ox;
    logic signed [OUT_W-1:0] oy;
  } side_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] dir_x;
    logic signed [OUT_W-1:0] dir_y;
    logic signed [OUT_W-1:0] dir_z;
    logic                    on_sphere;
    logic                    degenerate;
  } res_t;

  function automatic logic [OUT_W-1:0] sat_sm(input logic neg, input logic [AX_W-1:0] mag);
    logic [OUT_W-1:0] r;
    if (neg) begin
      r = (mag > AX_W'(OUT_MAX + 1)) ? OUT_W'(OUT_MAX + 1) : OUT_W'(AX_W'(0) - mag);
    end else begin
      r = (mag > AX_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : mag[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: sv/tvp_front.sv
// ----------------------------------------------------------------------------
// tvp_front
// Takes cursor beats, centers them on the rectangle, flags a degenerate
// rectangle and queues the work for the back end.
// ----------------------------------------------------------------------------
module tvp_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic signed [tvp_pkg::CUR_W-1:0]   cursor_x,
  input  logic signed [tvp_pkg::CUR_W-1:0]   cursor_y,
  input  tvp_pkg::cfg_t                      cfg,
  output tvp_pkg::fq_t                       head,
  output logic                               head_vld,
  input  logic                               head_pop
);
  import tvp_pkg::*;

  logic signed [PIX_W:0]   w, h, s;
  logic [PIX_W:0]          cx_sum, cy_sum;
  fq_t                     ent;
  fq_t                     q_r [QDEPTH];
  logic [QPTR_W-1:0]       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                    acc, pop;

  always_comb begin
    w      = $signed({1'b0, cfg.xmax}) - $signed({1'b0, cfg.xmin});
    h      = $signed({1'b0, cfg.ymax}) - $signed({1'b0, cfg.ymin});
    s      = (w < h) ? w : h;
    cx_sum = {1'b0, cfg.xmin} + {1'b0, cfg.xmax};
    cy_sum = {1'b0, cfg.ymin} + {1'b0, cfg.ymax};
    ent.degen = (s <= 0);
    ent.dx    = DLT_W'(cursor_x) - $signed({2'b00, cx_sum[PIX_W:1]});
    ent.dy    = DLT_W'(cursor_y) - $signed({2'b00, cy_sum[PIX_W:1]});
    ent.s     = s[PIX_W-1:0];
  end

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign head_vld = (cnt_r != '0);
  assign head     = q_r[rd_r];
  assign acc      = push && !full;
  assign pop      = head_pop && head_vld;

  always_comb begin
    wr_nxt  = acc ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(acc) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wr_r] <= ent;
    end
  end

endmodule

// File: sv/tvp_back.sv
// ----------------------------------------------------------------------------
// tvp_back
// Pipelined scale dividers, squares, branch test, square root and z divider.
// One beat per cycle; the whole pipe holds while its last stage is blocked.
// ----------------------------------------------------------------------------
module tvp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tvp_pkg::fq_t                head,
  input  logic                        head_vld,
  output logic                        head_pop,
  input  logic [tvp_pkg::RAD_W-1:0]   radius,
  output tvp_pkg::res_t               res,
  output logic                        res_push,
  input  logic                        res_full
);
  import tvp_pkg::*;

  logic              adv;
  logic [R2_W-1:0]   r2_r;

  // scale dividers
  logic              dv_r [0:SQ_W];
  side_t             ds_r [0:SQ_W];
  logic [DEN_W-1:0]  dd_r [0:SQ_W];
  logic [SQ_W-1:0]   xa_r [0:SQ_W];
  logic [SQ_W-1:0]   ya_r [0:SQ_W];
  logic [DEN_W-1:0]  xr_r [0:SQ_W];
  logic [DEN_W-1:0]  yr_r [0:SQ_W];
  logic [DLT_W-1:0]  ax16, ay16;

  // squares and sum
  logic              mv_r, sv_r;
  side_t             ms_r, ss_r;
  logic [AX2_W-1:0]  mx2_r, my2_r;
  logic [SUM_W-1:0]  sum_r;
  logic [AX_W-1:0]   axc, ayc;

  // square root
  logic              qv_r [0:RT_W];
  side_t             qs_r [0:RT_W];
  logic [V_W-1:0]    qd_r [0:RT_W];
  logic [RT_W-1:0]   qt_r [0:RT_W];
  logic [RM_W-1:0]   qm_r [0:RT_W];
  logic              sph;
  logic [V_W-1:0]    vin;

  // rounding and z divider
  logic              rv_r;
  side_t             rs_r;
  logic [SR_W-1:0]   sr_r;
  logic              zv_r [0:ZW];
  side_t             zs_r [0:ZW];
  logic [SR_W-1:0]   zq_r [0:ZW];
  logic [ZW-1:0]     za_r [0:ZW];
  logic [ZW-1:0]     zr_r [0:ZW];
  logic [ZW-1:0]     zd_r [0:ZW];

  // output
  logic              vo_r;
  res_t              o_r;
  res_t              o_nxt;
  logic [ZW-1:0]     zraw;

  assign adv      = !(vo_r && res_full);
  assign head_pop = head_vld && adv;
  assign res_push = vo_r && !res_full;
  assign res      = o_r;

  always_ff @(posedge clk) begin
    r2_r <= R2_W'(radius) * R2_W'(radius);
  end

  // ---- prep ----
  always_comb begin
    ax16 = head.dx[DLT_W-1] ? DLT_W'(-head.dx) : DLT_W'(head.dx);
    ay16 = head.dy[DLT_W-1] ? DLT_W'(-head.dy) : DLT_W'(head.dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= head_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds_r[0].degen  <= head.degen;
      ds_r[0].nx     <= head.dx[DLT_W-1];
      ds_r[0].ny     <= head.dy[DLT_W-1];
      ds_r[0].sphere <= 1'b0;
      ds_r[0].ox     <= '0;
      ds_r[0].oy     <= '0;
      dd_r[0]        <= {head.s, 1'b0};
      xa_r[0]        <= (SQ_W'(ax16[MAG_W-1:0]) << (FRAC_BITS + 2)) + SQ_W'(head.s);
      ya_r[0]        <= (SQ_W'(ay16[MAG_W-1:0]) << (FRAC_BITS + 2)) + SQ_W'(head.s);
      xr_r[0]        <= '0;
      yr_r[0]        <= '0;
    end
  end

  for (genvar i = 0; i < SQ_W; i++) begin : g_sdiv
    logic [DEN_W:0] tx, ty;
    logic           gx, gy;
    always_comb begin
      tx = {xr_r[i], xa_r[i][SQ_W-1]};
      ty = {yr_r[i], ya_r[i][SQ_W-1]};
      gx = (tx >= {1'b0, dd_r[i]});
      gy = (ty >= {1'b0, dd_r[i]});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i+1] <= 1'b0;
      end else if (adv) begin
        dv_r[i+1] <= dv_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ds_r[i+1] <= ds_r[i];
        dd_r[i+1] <= dd_r[i];
        xa_r[i+1] <= {xa_r[i][SQ_W-2:0], gx};
        ya_r[i+1] <= {ya_r[i][SQ_W-2:0], gy};
        xr_r[i+1] <= gx ? DEN_W'(tx - {1'b0, dd_r[i]}) : tx[DEN_W-1:0];
        yr_r[i+1] <= gy ? DEN_W'(ty - {1'b0, dd_r[i]}) : ty[DEN_W-1:0];
      end
    end
  end

  // ---- clamp, saturate, square ----
  always_comb begin
    axc = (64'(xa_r[SQ_W]) > 64'(CAP)) ? AX_W'(CAP) : AX_W'(xa_r[SQ_W]);
    ayc = (64'(ya_r[SQ_W]) > 64'(CAP)) ? AX_W'(CAP) : AX_W'(ya_r[SQ_W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (adv) begin
      mv_r <= dv_r[SQ_W];
      sv_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ms_r    <= '{degen: ds_r[SQ_W].degen, nx: ds_r[SQ_W].nx, ny: ds_r[SQ_W].ny,
                   sphere: ds_r[SQ_W].sphere, ox: sat_sm(ds_r[SQ_W].nx, axc),
                   oy: sat_sm(ds_r[SQ_W].ny, ayc)};
      mx2_r   <= axc * axc;
      my2_r   <= ayc * ayc;
      ss_r    <= ms_r;
      sum_r   <= SUM_W'(mx2_r) + SUM_W'(my2_r);
    end
  end

  // ---- branch test and root operand ----
  always_comb begin
    sph = ({sum_r, 1'b0} < V_W'(r2_r));
    vin = sph ? V_W'(r2_r) - V_W'(sum_r) : V_W'(sum_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r[0] <= 1'b0;
    end else if (adv) begin
      qv_r[0] <= sv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qs_r[0]        <= '{degen: ss_r.degen, nx: ss_r.nx, ny: ss_r.ny, sphere: sph,
                          ox: ss_r.ox, oy: ss_r.oy};
      qd_r[0]        <= vin;
      qt_r[0]        <= '0;
      qm_r[0]        <= '0;
    end
  end

  for (genvar i = 0; i < RT_W; i++) begin : g_sqrt
    logic [RM_W+1:0] t, trial;
    logic            g;
    always_comb begin
      t     = {qm_r[i], qd_r[i][V_W-1 -: 2]};
      trial = (RM_W + 2)'({qt_r[i], 2'b01});
      g     = (t >= trial);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qv_r[i+1] <= 1'b0;
      end else if (adv) begin
        qv_r[i+1] <= qv_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        qs_r[i+1] <= qs_r[i];
        qd_r[i+1] <= {qd_r[i][V_W-3:0], 2'b00};
        qt_r[i+1] <= {qt_r[i][RT_W-2:0], g};
        qm_r[i+1] <= g ? RM_W'(t - trial) : RM_W'(t);
      end
    end
  end

  // ---- round to nearest, load z divider ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r    <= 1'b0;
      zv_r[0] <= 1'b0;
    end else if (adv) begin
      rv_r    <= qv_r[RT_W];
      zv_r[0] <= rv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rs_r    <= qs_r[RT_W];
      sr_r    <= SR_W'(qt_r[RT_W]) + SR_W'(qm_r[RT_W] > RM_W'(qt_r[RT_W]));
      zs_r[0] <= rs_r;
      zq_r[0] <= sr_r;
      za_r[0] <= ZW'(r2_r) + ZW'(sr_r);
      zd_r[0] <= ZW'({sr_r, 1'b0});
      zr_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < ZW; i++) begin : g_zdiv
    logic [ZW:0] t;
    logic        g;
    always_comb begin
      t = {zr_r[i], za_r[i][ZW-1]};
      g = (t >= {1'b0, zd_r[i]});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        zv_r[i+1] <= 1'b0;
      end else if (adv) begin
        zv_r[i+1] <= zv_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        zs_r[i+1] <= zs_r[i];
        zq_r[i+1] <= zq_r[i];
        zd_r[i+1] <= zd_r[i];
        za_r[i+1] <= {za_r[i][ZW-2:0], g};
        zr_r[i+1] <= g ? ZW'(t - {1'b0, zd_r[i]}) : t[ZW-1:0];
      end
    end
  end

  // ---- output stage ----
  always_comb begin
    if (zs_r[ZW].sphere) begin
      zraw = ZW'(zq_r[ZW]);
    end else if (zq_r[ZW] == '0) begin
      zraw = '0;
    end else begin
      zraw = za_r[ZW];
    end
    if (zs_r[ZW].degen) begin
      o_nxt = '0;
      o_nxt.degenerate = 1'b1;
    end else begin
      o_nxt.dir_x      = zs_r[ZW].ox;
      o_nxt.dir_y      = zs_r[ZW].oy;
      o_nxt.dir_z      = (zraw > ZW'(OUT_MAX)) ? OUT_W'(OUT_MAX) : zraw[OUT_W-1:0];
      o_nxt.on_sphere  = zs_r[ZW].sphere;
      o_nxt.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (adv) begin
      vo_r <= zv_r[ZW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_r <= o_nxt;
    end
  end

endmodule

// File: sv/tvp_outq.sv
// ----------------------------------------------------------------------------
// tvp_outq
// Result queue; keeps the pipe moving while the consumer stalls.
// ----------------------------------------------------------------------------
module tvp_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tvp_pkg::res_t  din,
  output logic           full,
  input  logic           pop,
  output tvp_pkg::res_t  dout,
  output logic           empty
);
  import tvp_pkg::*;

  res_t               q_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               acc, take;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = q_r[rd_r];
  assign acc   = push && !full;
  assign take  = pop && !empty;

  always_comb begin
    wr_nxt  = acc  ? wr_r + 1'b1 : wr_r;
    rd_nxt  = take ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(acc) - QCNT_W'(take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wr_r] <= din;
    end
  end

endmodule

// File: sv/trackball_vector_projection.sv
// ----------------------------------------------------------------------------
// trackball_vector_projection
// Virtual trackball: cursor position to sphere / hyperbolic-sheet direction.
// ----------------------------------------------------------------------------
// Takes one cursor beat per clock while the cursor queue is not full and returns
// one direction beat per cursor beat, in order. A result passes through the
// bit-per-stage pipelines: the scale dividers (30 stages), the square root
// (32 stages) and the z divider (34 stages). Results wait in a 4-entry queue;
// the cursor side has its own 4-entry queue. Program the rectangle and radius
// over APB only while no beat is in flight.
module trackball_vector_projection (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic signed [tvp_pkg::CUR_W-1:0]   in_cursor_x,
  input  logic signed [tvp_pkg::CUR_W-1:0]   in_cursor_y,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [tvp_pkg::OUT_W-1:0]   out_dir_x,
  output logic signed [tvp_pkg::OUT_W-1:0]   out_dir_y,
  output logic signed [tvp_pkg::OUT_W-1:0]   out_dir_z,
  output logic                               out_on_sphere,
  output logic                               out_degenerate,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tvp_pkg::ADDR_W-1:0]         paddr,
  input  logic [tvp_pkg::DATA_W-1:0]         pwdata,
  output logic [tvp_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import tvp_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  reg_idx_t  idx;
  logic      wr;
  fq_t       head;
  logic      head_vld, head_pop;
  res_t      bres, ores;
  logic      back_push, oq_full;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_XMIN:   cfg_nxt.xmin   = pwdata[PIX_W-1:0];
        REG_XMAX:   cfg_nxt.xmax   = pwdata[PIX_W-1:0];
        REG_YMIN:   cfg_nxt.ymin   = pwdata[PIX_W-1:0];
        REG_YMAX:   cfg_nxt.ymax   = pwdata[PIX_W-1:0];
        REG_RADIUS: cfg_nxt.radius = pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_XMIN:   prdata = DATA_W'(cfg_r.xmin);
      REG_XMAX:   prdata = DATA_W'(cfg_r.xmax);
      REG_YMIN:   prdata = DATA_W'(cfg_r.ymin);
      REG_YMAX:   prdata = DATA_W'(cfg_r.ymax);
      REG_RADIUS: prdata = DATA_W'(cfg_r.radius);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{xmin: '0, xmax: '0, ymin: '0, ymax: '0, radius: RADIUS_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tvp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .cursor_x (in_cursor_x),
    .cursor_y (in_cursor_y),
    .cfg      (cfg_r),
    .head     (head),
    .head_vld (head_vld),
    .head_pop (head_pop)
  );

  tvp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .head_vld (head_vld),
    .head_pop (head_pop),
    .radius   (cfg_r.radius),
    .res      (bres),
    .res_push (back_push),
    .res_full (oq_full)
  );

  tvp_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (back_push),
    .din   (bres),
    .full  (oq_full),
    .pop   (pop),
    .dout  (ores),
    .empty (empty)
  );

  assign out_dir_x      = ores.dir_x;
  assign out_dir_y      = ores.dir_y;
  assign out_dir_z      = ores.dir_z;
  assign out_on_sphere  = ores.on_sphere;
  assign out_degenerate = ores.degenerate;

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    back_push |-> !oq_full) else $error("result pushed into full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> head_vld) else $error("work queue popped while empty");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_degenerate) |-> (out_dir_x == '0 && out_dir_y == '0 &&
      out_dir_z == '0 && !out_on_sphere)) else $error("degenerate beat not zeroed");

  a_z_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !out_dir_z[OUT_W-1]) else $error("negative z");
`endif

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the trackball projection.
// ----------------------------------------------------------------------------
// Cursor beats are pushed against a predicted direction queue. The rectangle
// and radius are reprogrammed over APB between phases while the block is
// idle. Directed rows come first, then phases of random cursors. Push and
// pop idle at random.
`timescale 1ns / 100ps

module tb;
  import tvp_pkg::*;

  localparam int  RAND_PER_PHASE = 275;
  localparam int  PHASES         = 6;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  logic signed [CUR_W-1:0] in_cursor_x;
  logic signed [CUR_W-1:0] in_cursor_y;
  logic empty;
  logic pop;
  logic signed [OUT_W-1:0] out_dir_x;
  logic signed [OUT_W-1:0] out_dir_y;
  logic signed [OUT_W-1:0] out_dir_z;
  logic out_on_sphere;
  logic out_degenerate;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  trackball_vector_projection u_top (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_cursor_x(in_cursor_x), .in_cursor_y(in_cursor_y),
    .empty(empty), .pop(pop),
    .out_dir_x(out_dir_x), .out_dir_y(out_dir_y), .out_dir_z(out_dir_z),
    .out_on_sphere(out_on_sphere), .out_degenerate(out_degenerate),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct {
    logic [PIX_W-1:0] xmin;
    logic [PIX_W-1:0] xmax;
    logic [PIX_W-1:0] ymin;
    logic [PIX_W-1:0] ymax;
    logic [RAD_W-1:0] radius;
  } rect_cfg_t;

  typedef struct {
    logic signed [CUR_W-1:0] cx;
    logic signed [CUR_W-1:0] cy;
    logic                    known;
    res_t                    dir;
  } cursor_row_t;

  rect_cfg_t   shadow_cfg;
  res_t        dir_queue[$];
  int          errors;
  longint      cycle_count;
  bit          pop_enable;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("trackball_vector_projection regression: fail");
      $finish;
    end
  end

  function automatic longint unsigned isqrt_round(input longint unsigned v);
    longint unsigned res, bitv, rem;
    res = 0;
    rem = v;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (v - res * res > res) res++;
    return res;
  endfunction

  function automatic longint unsigned scaled_mag(input longint unsigned mag,
                                                 input longint unsigned s);
    longint unsigned num, q;
    num = mag << (FRAC_BITS + 1);
    q = (2 * num + s) / (2 * s);
    return (q > CAP) ? CAP : q;
  endfunction

  function automatic logic [OUT_W-1:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[OUT_W-1:0];
  endfunction

  function automatic res_t project_cursor(input logic signed [CUR_W-1:0] cx,
                                          input logic signed [CUR_W-1:0] cy);
    res_t r;
    longint w, h, s, dx, dy, zq;
    longint unsigned ax, ay, sum, r2, d;
    logic sphere;
    w = longint'(shadow_cfg.xmax) - longint'(shadow_cfg.xmin);
    h = longint'(shadow_cfg.ymax) - longint'(shadow_cfg.ymin);
    s = (w < h) ? w : h;
    r = '0;
    if (s <= 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    dx = longint'(cx) - longint'((longint'(shadow_cfg.xmin) + shadow_cfg.xmax) / 2);
    dy = longint'(cy) - longint'((longint'(shadow_cfg.ymin) + shadow_cfg.ymax) / 2);
    ax = scaled_mag(dx < 0 ? -dx : dx, s);
    ay = scaled_mag(dy < 0 ? -dy : dy, s);
    sum = ax * ax + ay * ay;
    r2 = longint'(shadow_cfg.radius) * shadow_cfg.radius;
    sphere = (2 * sum < r2);
    if (sphere) begin
      zq = isqrt_round(r2 - sum);
    end else begin
      d = isqrt_round(sum);
      zq = (d == 0) ? 0 : (r2 + d) / (2 * d);
    end
    r.dir_x = clip16(dx < 0 ? -longint'(ax) : longint'(ax));
    r.dir_y = clip16(dy < 0 ? -longint'(ay) : longint'(ay));
    r.dir_z = clip16(zq);
    r.on_sphere = sphere;
    return r;
  endfunction

  task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_XMIN:   shadow_cfg.xmin   = val[PIX_W-1:0];
      REG_XMAX:   shadow_cfg.xmax   = val[PIX_W-1:0];
      REG_YMIN:   shadow_cfg.ymin   = val[PIX_W-1:0];
      REG_YMAX:   shadow_cfg.ymax   = val[PIX_W-1:0];
      REG_RADIUS: shadow_cfg.radius = val[RAD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_rect(input rect_cfg_t c);
    // upper bits are junk on purpose; the block keeps only the register width
    apb_write(REG_XMIN,   {$urandom} << PIX_W | DATA_W'(c.xmin));
    apb_write(REG_XMAX,   {$urandom} << PIX_W | DATA_W'(c.xmax));
    apb_write(REG_YMIN,   {$urandom} << PIX_W | DATA_W'(c.ymin));
    apb_write(REG_YMAX,   {$urandom} << PIX_W | DATA_W'(c.ymax));
    apb_write(REG_RADIUS, {$urandom} << RAD_W | DATA_W'(c.radius));
  endtask

  task automatic send_cursor(input logic signed [CUR_W-1:0] cx,
                             input logic signed [CUR_W-1:0] cy,
                             input bit known, input res_t dir);
    int gap;
    res_t want;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    want = known ? dir : project_cursor(cx, cy);
    push        <= 1'b1;
    in_cursor_x <= cx;
    in_cursor_y <= cy;
    do @(posedge clk); while (full);
    dir_queue.push_back(want);
  endtask

  task automatic drain_and_settle();
    push <= 1'b0;
    while (dir_queue.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // result side
  int pop_wait;
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        res_t want;
        if (dir_queue.size() == 0) begin
          $error("unexpected direction beat");
          errors++;
        end else begin
          want = dir_queue.pop_front();
          if (out_dir_x !== want.dir_x) begin
            $error("dir_x exp %0d got %0d", want.dir_x, out_dir_x); errors++;
          end
          if (out_dir_y !== want.dir_y) begin
            $error("dir_y exp %0d got %0d", want.dir_y, out_dir_y); errors++;
          end
          if (out_dir_z !== want.dir_z) begin
            $error("dir_z exp %0d got %0d", want.dir_z, out_dir_z); errors++;
          end
          if (out_on_sphere !== want.on_sphere) begin
            $error("on_sphere exp %0b got %0b", want.on_sphere, out_on_sphere); errors++;
          end
          if (out_degenerate !== want.degenerate) begin
            $error("degenerate exp %0b got %0b", want.degenerate, out_degenerate); errors++;
          end
        end
        pop_wait = pop_enable ? $urandom_range(0, 3) : 0;
        pop <= (pop_wait == 0);
      end else if (!pop) begin
        if (pop_wait > 0) pop_wait--;
        pop <= (pop_wait == 0);
      end
    end
  end

  cursor_row_t dir_rows[$];
  rect_cfg_t   phase_cfg[PHASES];

  function automatic res_t mk_dir(input int x, y, z, input bit sph, dg);
    res_t r;
    r.dir_x = OUT_W'(x); r.dir_y = OUT_W'(y); r.dir_z = OUT_W'(z);
    r.on_sphere = sph; r.degenerate = dg;
    return r;
  endfunction

  function automatic logic signed [CUR_W-1:0] rand_cursor(input rect_cfg_t c,
                                                          input bit x_axis);
    int lo, hi;
    lo = x_axis ? c.xmin : c.ymin;
    hi = x_axis ? c.xmax : c.ymax;
    if (hi < lo) begin int t; t = lo; lo = hi; hi = t; end
    case ($urandom_range(0, 3))
      0:       return CUR_W'($urandom);
      default: return CUR_W'($urandom_range(lo, hi));
    endcase
  endfunction

  initial begin
    rect_cfg_t c;
    cycle_count = 0;
    errors      = 0;
    pop_enable  = 1'b0;
    pop_wait    = 0;
    rst_n       = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    in_cursor_x = '0;
    in_cursor_y = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    shadow_cfg  = '{xmin: 0, xmax: 0, ymin: 0, ymax: 0, radius: RADIUS_RST};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    pop   <= 1'b1;
    @(posedge clk);

    // after reset the rectangle is empty: flagged, zero direction
    send_cursor(15'sd100, -15'sd100, 1'b1, mk_dir(0, 0, 0, 1'b0, 1'b1));
    send_cursor(15'sh3fff, 15'sh4000, 1'b1, mk_dir(0, 0, 0, 1'b0, 1'b1));
    drain_and_settle();

    // centered 0..200 square, default radius
    load_rect('{xmin: 0, xmax: 200, ymin: 0, ymax: 200, radius: RADIUS_RST});
    // center: z is the radius on the sphere
    dir_rows.push_back('{cx: 100, cy: 100, known: 1, dir: mk_dir(0, 0, 4506, 1, 0)});
    // rectangle edges map to +/-1.0
    dir_rows.push_back('{cx: 200, cy: 100, known: 0, dir: '0});
    dir_rows.push_back('{cx: 0,   cy: 100, known: 0, dir: '0});
    dir_rows.push_back('{cx: 100, cy: 0,   known: 0, dir: '0});
    dir_rows.push_back('{cx: 150, cy: 170, known: 0, dir: '0});
    // extremes saturate both components
    dir_rows.push_back('{cx: 15'sh3fff, cy: 15'sh3fff, known: 0, dir: '0});
    dir_rows.push_back('{cx: 15'sh4000, cy: 15'sh4000, known: 0, dir: '0});
    dir_rows.push_back('{cx: 15'sh4000, cy: 15'sh3fff, known: 0, dir: '0});
    dir_rows.push_back('{cx: 0,   cy: 0,   known: 0, dir: '0});
    foreach (dir_rows[i])
      send_cursor(dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].known, dir_rows[i].dir);
    dir_rows.delete();
    drain_and_settle();

    // inverted rectangle: flagged
    load_rect('{xmin: 500, xmax: 20, ymin: 0, ymax: 300, radius: 15'd1});
    send_cursor(15'sd10, 15'sd10, 1'b1, mk_dir(0, 0, 0, 1'b0, 1'b1));
    drain_and_settle();
    // one-pixel tiny square, zero radius: hyperbola, center gives z 0
    load_rect('{xmin: 7, xmax: 8, ymin: 7, ymax: 8, radius: 15'd0});
    send_cursor(15'sd7, 15'sd7, 1'b1, mk_dir(0, 0, 0, 1'b0, 1'b0));
    send_cursor(15'sd9, -15'sd16384, 1'b0, '0);
    drain_and_settle();
    // full-size region, largest radius
    load_rect('{xmin: 0, xmax: 16383, ymin: 0, ymax: 16383, radius: 15'h7fff});
    send_cursor(15'sd8191, 15'sd8191, 1'b1, mk_dir(0, 0, 32767, 1'b1, 1'b0));
    send_cursor(15'sh4000, 15'sh4000, 1'b0, '0);
    send_cursor(15'sh3fff, 15'sd0, 1'b0, '0);
    drain_and_settle();

    pop_enable = 1'b1;
    phase_cfg[0] = '{xmin: 0, xmax: 640, ymin: 0, ymax: 480, radius: RADIUS_RST};
    phase_cfg[1] = '{xmin: 16383, xmax: 16383, ymin: 0, ymax: 16383, radius: 15'd4096};
    phase_cfg[2] = '{xmin: 0, xmax: 16383, ymin: 16382, ymax: 16383, radius: 15'h7fff};
    phase_cfg[3] = '{xmin: 3, xmax: 5, ymin: 100, ymax: 9000, radius: 15'd1};
    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        c = phase_cfg[p];
      end else begin
        c.xmin = PIX_W'($urandom); c.xmax = PIX_W'($urandom);
        c.ymin = PIX_W'($urandom); c.ymax = PIX_W'($urandom);
        c.radius = RAD_W'($urandom_range(0, 32767));
        if (c.xmax < c.xmin) begin
          c.xmax = c.xmin; c.xmin = PIX_W'($urandom_range(0, c.xmax));
        end
        if (c.ymax < c.ymin) begin
          c.ymax = c.ymin; c.ymin = PIX_W'($urandom_range(0, c.ymax));
        end
      end
      load_rect(c);
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        // ramp the pop stalls off now and then for a burst at full rate
        if (k % 100 == 50) pop_enable = ~pop_enable;
        send_cursor(rand_cursor(c, 1'b1), rand_cursor(c, 1'b0), 1'b0, '0);
        if (k == 150) begin
          push <= 1'b0;
          while (dir_queue.size() != 0) @(posedge clk);
        end
      end
      pop_enable = 1'b1;
      drain_and_settle();
    end

    if (errors == 0) begin
      $display("trackball_vector_projection regression: pass");
    end else begin
      $display("trackball_vector_projection regression: fail");
    end
    $finish;
  end

endmodule

// File: trackball_vector_projection.f
sv/tvp_pkg.sv
sv/tvp_front.sv
sv/tvp_back.sv
sv/tvp_outq.sv
sv/trackball_vector_projection.sv
sim/tb.sv
